// ===== rtl/core/linked_wait_queue_top_macros.svh =====
// assertion helpers for the linked wait queue
`ifndef LINKED_WAIT_QUEUE_TOP_MACROS_SVH
`define LINKED_WAIT_QUEUE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, disabled while reset is asserted
`define LWQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, disabled while reset is asserted
`define LWQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define LWQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define LWQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== rtl/core/lwq_pkg.sv =====
`default_nettype none

package lwq_pkg;

  // default number of nodes the queue can hold
  localparam int unsigned NODES_DEFAULT = 64;

  // request kinds
  typedef enum logic [1:0] {
    KindEnq = 2'd0,
    KindDeq = 2'd1,
    KindRem = 2'd2
  } kind_e;

endpackage

`default_nettype wire

// ===== rtl/core/linked_wait_queue_top.sv =====
// Linked wait queue: a first-in-first-out queue of node ids kept as a doubly
// linked list in two link memories (previous and next), with head, tail, count
// and a per-node queued mark in flip-flops. A request is taken when start is
// high and busy is low; it passes through a request cycle, which reads the
// link memories, and an execute cycle, which writes the neighbor links; busy
// holds off a new request in the execute cycle. The result appears on the
// result ports for exactly one cycle, marked by done_o, in the cycle after the
// execute cycle; the receiver cannot stall it, and the next request may be
// taken in that same cycle. Enqueue of a queued or out-of-range node, dequeue
// of an empty queue, remove of a node that is not queued and an unknown kind
// all return ok low and change nothing. No clearing pass runs after reset: the
// queued marks clear at once and links are only read for queued nodes.
`default_nettype none

`include "linked_wait_queue_top_macros.svh"

module linked_wait_queue_top #(
  parameter int unsigned NODES = lwq_pkg::NODES_DEFAULT
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   kind_i,
  input  wire logic [$clog2(NODES)-1:0]     node_id_i,
  output logic                              done_o,
  output logic                              ok_o,
  output logic      [$clog2(NODES)-1:0]     out_node_o,
  output logic      [$clog2(NODES+1)-1:0]   queue_count_o
);

  // node id width and pointer width (pointers also carry the null code)
  localparam int unsigned IW = $clog2(NODES);
  localparam int unsigned PW = $clog2(NODES + 1);
  localparam logic [PW-1:0] NULL_PTR = PW'(NODES);

  // sequencer codes
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic          state_q, state_d;
  logic [1:0]    kind_q;
  logic [IW-1:0] node_q;
  logic          take_q, take_d;
  logic [IW-1:0] target_d;

  logic [PW-1:0]    head_q, head_d;
  logic [PW-1:0]    tail_q, tail_d;
  logic [PW-1:0]    count_q, count_d;
  logic [NODES-1:0] in_queue_q, in_queue_d;

  logic          done_q;
  logic          res_ok_q;
  logic [IW-1:0] res_node_q;
  logic [PW-1:0] res_count_q;

  // link memory ports
  logic          prev_we, next_we;
  logic [IW-1:0] prev_waddr, next_waddr;
  logic [PW-1:0] prev_wdata, next_wdata;
  logic [PW-1:0] prev_rd, next_rd;

  logic accept;
  logic node_valid;
  logic head_valid;
  logic tail_valid;
  logic prev_valid;
  logic next_valid;

  assign busy   = (state_q == ST_EXEC);
  assign accept = start && !busy;

  assign node_valid = (PW'(node_id_i) < NULL_PTR);
  assign head_valid = (head_q < NULL_PTR);
  assign tail_valid = (tail_q < NULL_PTR);
  // links read for the target; anything not below the node count is null
  assign prev_valid = (prev_rd < NULL_PTR);
  assign next_valid = (next_rd < NULL_PTR);

  // request cycle: decide whether the request takes effect and pick the target
  always_comb begin
    take_d   = 1'b0;
    target_d = node_id_i;
    unique case (kind_i)
      lwq_pkg::KindEnq: begin
        take_d = node_valid && !in_queue_q[node_id_i];
      end
      lwq_pkg::KindDeq: begin
        take_d   = head_valid;
        target_d = head_q[IW-1:0];
      end
      lwq_pkg::KindRem: begin
        take_d = node_valid && in_queue_q[node_id_i];
      end
      default: begin
        take_d = 1'b0;
      end
    endcase
  end

  // memory writes: enqueue sets its own links in the request cycle, the
  // execute cycle patches the neighbors
  always_comb begin
    prev_we    = 1'b0;
    prev_waddr = node_id_i;
    prev_wdata = tail_q;
    next_we    = 1'b0;
    next_waddr = node_id_i;
    next_wdata = NULL_PTR;
    if (accept && take_d && (kind_i == lwq_pkg::KindEnq)) begin
      prev_we = 1'b1;
      next_we = 1'b1;
    end else if ((state_q == ST_EXEC) && take_q) begin
      unique case (kind_q) inside
        lwq_pkg::KindEnq: begin
          // old tail points forward to the new node
          next_we    = tail_valid;
          next_waddr = tail_q[IW-1:0];
          next_wdata = PW'(node_q);
        end
        lwq_pkg::KindDeq, lwq_pkg::KindRem: begin
          // bridge the gap left by the target
          next_we    = prev_valid;
          next_waddr = prev_rd[IW-1:0];
          next_wdata = next_rd;
          prev_we    = next_valid;
          prev_waddr = next_rd[IW-1:0];
          prev_wdata = prev_rd;
        end
        default: begin
          next_we = 1'b0;
          prev_we = 1'b0;
        end
      endcase
    end
  end

  // execute cycle: update head, tail, count and queued marks
  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    in_queue_d = in_queue_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        if (take_q) begin
          unique case (kind_q) inside
            lwq_pkg::KindEnq: begin
              if (!tail_valid) begin
                head_d = PW'(node_q);
              end
              tail_d             = PW'(node_q);
              in_queue_d[node_q] = 1'b1;
              count_d            = count_q + PW'(1);
            end
            lwq_pkg::KindDeq, lwq_pkg::KindRem: begin
              if (!prev_valid) begin
                head_d = next_rd;
              end
              if (!next_valid) begin
                tail_d = prev_rd;
              end
              in_queue_d[node_q] = 1'b0;
              if (count_q != '0) begin
                count_d = count_q - PW'(1);
              end
            end
            default: begin
              count_d = count_q;
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      head_q     <= NULL_PTR;
      tail_q     <= NULL_PTR;
      count_q    <= '0;
      in_queue_q <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
      in_queue_q <= in_queue_d;
      done_q     <= (state_q == ST_EXEC);
    end
  end

  // request latch, payload only
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      node_q <= target_d;
      take_q <= take_d;
    end
  end

  // result register, shown for one cycle under done_o
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXEC) begin
      res_ok_q    <= take_q;
      res_node_q  <= (take_q && (kind_q == lwq_pkg::KindDeq)) ? node_q : '0;
      res_count_q <= count_d;
    end
  end

  assign done_o        = done_q;
  assign ok_o          = res_ok_q;
  assign out_node_o    = res_node_q;
  assign queue_count_o = res_count_q;

  // previous links, read for the target in the request cycle
  lwq_link_ram #(
    .DEPTH (NODES),
    .DW    (PW)
  ) u_prev_ram (
    .clk_i     (clk_i),
    .wr_en_i   (prev_we),
    .wr_addr_i (prev_waddr),
    .wr_data_i (prev_wdata),
    .rd_en_i   (accept),
    .rd_addr_i (target_d),
    .rd_data_o (prev_rd)
  );

  // next links, same read address
  lwq_link_ram #(
    .DEPTH (NODES),
    .DW    (PW)
  ) u_next_ram (
    .clk_i     (clk_i),
    .wr_en_i   (next_we),
    .wr_addr_i (next_waddr),
    .wr_data_i (next_wdata),
    .rd_en_i   (accept),
    .rd_addr_i (target_d),
    .rd_data_o (next_rd)
  );

  // checks on the sequencing and on the list bookkeeping
  `LWQ_ASSERT_NXT(a_accept_exec, clk_i, rst_ni, accept, (state_q == ST_EXEC),
                  "accepted request did not enter execute")
  `LWQ_ASSERT_IMP(a_done_after_exec, clk_i, rst_ni, done_o, ($past(state_q) == ST_EXEC),
                  "result strobe without an execute cycle")
  `LWQ_ASSERT_IMP(a_empty_ends, clk_i, rst_ni, (count_q == '0),
                  ((head_q == NULL_PTR) && (tail_q == NULL_PTR)),
                  "empty queue with a live head or tail")
  `LWQ_ASSERT_IMP(a_marks_count, clk_i, rst_ni, 1'b1,
                  ($countones(in_queue_q) == int'(count_q)),
                  "queued marks disagree with count")

endmodule

`default_nettype wire

// ===== rtl/core/lwq_link_ram.sv =====
`default_nettype none

module lwq_link_ram #(
  parameter int unsigned DEPTH = lwq_pkg::NODES_DEFAULT,
  parameter int unsigned DW    = $clog2(lwq_pkg::NODES_DEFAULT + 1)
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [DW-1:0]            wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [DW-1:0]            rd_data_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read returns the contents before a write at the same edge
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== tb/tb_linked_wait_queue_top.sv =====
module tb_linked_wait_queue_top;

  // sizes follow the block's default node count
  localparam int unsigned NodeCount = lwq_pkg::NODES_DEFAULT;
  localparam int unsigned IdW = $clog2(NodeCount);
  localparam int unsigned CntW = $clog2(NodeCount + 1);
  // link value that marks no neighbor
  localparam logic [IdW:0] NullLink = (IdW + 1)'(NodeCount);
  // the one request kind that the package leaves undefined
  localparam logic [1:0] KindBad = 2'd3;
  // cycles with no request or reply accepted before the run is abandoned
  localparam int unsigned StallLimit = 1000;
  // quiet cycles after the last reply, to catch stray strobes
  localparam int unsigned DrainCycles = 8;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  logic [1:0] kind_i;
  logic [IdW-1:0] node_id_i;
  logic done_o;
  logic ok_o;
  logic [IdW-1:0] out_node_o;
  logic [CntW-1:0] queue_count_o;

  // one reply as the block reports it
  typedef struct packed {
    logic ok;
    logic [IdW-1:0] node;
    logic [CntW-1:0] count;
  } reply_t;

  // replies owed by the block, oldest first
  reply_t expected_replies[$];

  // shadow of the wait queue: head, tail, count, links and queued marks
  logic [IdW:0] head_link;
  logic [IdW:0] tail_link;
  int unsigned queued_total;
  logic [IdW:0] prev_tbl[NodeCount];
  logic [IdW:0] next_tbl[NodeCount];
  bit queued[NodeCount];

  int unsigned error_count = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_cycles = 0;

  linked_wait_queue_top dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .kind_i(kind_i),
    .node_id_i(node_id_i),
    .done_o(done_o),
    .ok_o(ok_o),
    .out_node_o(out_node_o),
    .queue_count_o(queue_count_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // empty queue, every link null, no node queued
  function automatic void clear_shadow();
    head_link = NullLink;
    tail_link = NullLink;
    queued_total = 0;
    for (int i = 0; i < NodeCount; i++) begin
      prev_tbl[i] = NullLink;
      next_tbl[i] = NullLink;
      queued[i] = 1'b0;
    end
  endfunction

  // splice a queued node out: its neighbors point past it, or head/tail move
  function automatic void splice_out(int unsigned n);
    logic [IdW:0] p;
    logic [IdW:0] q;
    p = prev_tbl[n];
    q = next_tbl[n];
    if (p < NodeCount) next_tbl[p] = q;
    else head_link = q;
    if (q < NodeCount) prev_tbl[q] = p;
    else tail_link = p;
    prev_tbl[n] = NullLink;
    next_tbl[n] = NullLink;
    queued[n] = 1'b0;
    if (queued_total > 0) queued_total--;
  endfunction

  // apply one request to the shadow queue and return the reply it must give
  function automatic reply_t apply_queue_op(logic [1:0] k, logic [IdW-1:0] n);
    reply_t r;
    logic [IdW:0] h;
    r = '0;
    case (k)
      lwq_pkg::KindEnq: begin
        // a node already waiting cannot be appended twice
        if (!queued[n]) begin
          prev_tbl[n] = tail_link;
          next_tbl[n] = NullLink;
          queued[n] = 1'b1;
          if (tail_link < NodeCount) next_tbl[tail_link] = {1'b0, n};
          else head_link = {1'b0, n};
          tail_link = {1'b0, n};
          queued_total++;
          r.ok = 1'b1;
        end
      end
      lwq_pkg::KindDeq: begin
        h = head_link;
        if (h < NodeCount) begin
          splice_out(h);
          r.node = h[IdW-1:0];
          r.ok = 1'b1;
        end
      end
      lwq_pkg::KindRem: begin
        if (queued[n]) begin
          splice_out(n);
          r.ok = 1'b1;
        end
      end
      default: begin
        // undefined kind leaves everything alone
      end
    endcase
    r.count = queued_total[CntW-1:0];
    return r;
  endfunction

  // random node that is (or is not) waiting; falls back to any node
  function automatic logic [IdW-1:0] pick_node(bit want_queued);
    int unsigned first;
    int unsigned c;
    first = $urandom_range(NodeCount - 1);
    for (int i = 0; i < NodeCount; i++) begin
      c = (first + i) % NodeCount;
      if (queued[c] == want_queued) return c[IdW-1:0];
    end
    return first[IdW-1:0];
  endfunction

  // present one request and hold it until the block takes it; the task returns
  // at the accepting edge with start still high so that back-to-back requests
  // never see start dropped and raised in one step
  task automatic send_request(logic [1:0] k, logic [IdW-1:0] n);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      // junk on the payload while start is low must be ignored
      kind_i <= 2'($urandom);
      node_id_i <= IdW'($urandom);
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start <= 1'b1;
    kind_i <= k;
    node_id_i <= n;
    forever begin
      @(negedge clk_i);
      if (!busy) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    expected_replies.push_back(apply_queue_op(k, n));
  endtask

  // hand-picked corner cases: empty dequeue, idle remove, undefined kind,
  // double enqueue, removal at head, middle and tail, extreme node ids
  task automatic test_directed();
    send_request(lwq_pkg::KindDeq, IdW'(0));
    send_request(lwq_pkg::KindRem, IdW'(63));
    send_request(KindBad, IdW'(42));
    send_request(lwq_pkg::KindEnq, IdW'(0));
    send_request(lwq_pkg::KindEnq, IdW'(63));
    send_request(lwq_pkg::KindEnq, IdW'(0));
    send_request(lwq_pkg::KindEnq, IdW'(21));
    send_request(lwq_pkg::KindEnq, IdW'(42));
    send_request(KindBad, IdW'(21));
    send_request(lwq_pkg::KindRem, IdW'(63));
    send_request(lwq_pkg::KindRem, IdW'(42));
    send_request(lwq_pkg::KindRem, IdW'(0));
    send_request(lwq_pkg::KindRem, IdW'(0));
    send_request(lwq_pkg::KindDeq, IdW'(5));
    send_request(lwq_pkg::KindDeq, IdW'(0));
    send_request(lwq_pkg::KindEnq, IdW'(42));
    send_request(lwq_pkg::KindRem, IdW'(42));
    send_request(lwq_pkg::KindEnq, IdW'(63));
    send_request(lwq_pkg::KindEnq, IdW'(1));
    send_request(lwq_pkg::KindDeq, IdW'(0));
    send_request(lwq_pkg::KindDeq, IdW'(0));
    send_request(lwq_pkg::KindDeq, IdW'(63));
  endtask

  // fill all nodes in shuffled order, then drain by dequeues and removals
  task automatic test_full_queue();
    int unsigned order[NodeCount];
    int unsigned j;
    int unsigned tmp;
    for (int i = 0; i < NodeCount; i++) order[i] = i;
    for (int i = NodeCount - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < NodeCount; i++) send_request(lwq_pkg::KindEnq, order[i][IdW-1:0]);
    // full queue: every enqueue is a double
    send_request(lwq_pkg::KindEnq, IdW'($urandom));
    while (queued_total > 0) begin
      if ($urandom_range(1)) send_request(lwq_pkg::KindDeq, IdW'($urandom));
      else send_request(lwq_pkg::KindRem, pick_node(1'b1));
    end
    send_request(lwq_pkg::KindDeq, IdW'($urandom));
  endtask

  // mostly well-formed traffic around a wandering fill level, plus noise
  task automatic test_random(int unsigned count, int unsigned pct);
    int unsigned roll;
    int unsigned fill_goal;
    idle_pct = pct;
    fill_goal = $urandom_range(NodeCount);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) fill_goal = $urandom_range(NodeCount);
      roll = $urandom_range(99);
      if (roll < 4) begin
        send_request(KindBad, IdW'($urandom));
      end else if (roll < 14) begin
        // blind enqueue or remove: often a double or an idle node
        if ($urandom_range(1)) send_request(lwq_pkg::KindEnq, IdW'($urandom));
        else send_request(lwq_pkg::KindRem, IdW'($urandom));
      end else if ($urandom_range(99) < (queued_total < fill_goal ? 65 : 35)) begin
        send_request(lwq_pkg::KindEnq, pick_node(1'b0));
      end else if ($urandom_range(1)) begin
        send_request(lwq_pkg::KindDeq, IdW'($urandom));
      end else begin
        send_request(lwq_pkg::KindRem, pick_node(1'b1));
      end
    end
    idle_pct = 0;
  endtask

  // reply check and stall watchdog, both on the quiet falling edge
  always @(negedge clk_i) begin
    reply_t want;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: reply with none pending, actual ok %0d node %0d count %0d",
                   $time, ok_o, out_node_o, queue_count_o);
          error_count++;
        end else begin
          want = expected_replies.pop_front();
          if (ok_o !== want.ok) begin
            $display("%0t: ok mismatch, expected %0d actual %0d", $time, want.ok, ok_o);
            error_count++;
          end
          if (out_node_o !== want.node) begin
            $display("%0t: out_node mismatch, expected %0d actual %0d",
                     $time, want.node, out_node_o);
            error_count++;
          end
          if (queue_count_o !== want.count) begin
            $display("%0t: queue_count mismatch, expected %0d actual %0d",
                     $time, want.count, queue_count_o);
            error_count++;
          end
        end
      end
      if ((start === 1'b1 && busy === 1'b0) || done_o === 1'b1) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("%0t: no progress for %0d cycles", $time, stall_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_ni <= 1'b0;
    start <= 1'b0;
    kind_i <= lwq_pkg::KindEnq;
    node_id_i <= '0;
    clear_shadow();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_full_queue();
    // no idling, then a mostly idle sender, then a lightly idle one
    test_random(350, 0);
    test_random(350, 80);
    test_random(350, 12);
    start <= 1'b0;

    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/lwq_pkg.sv
rtl/core/lwq_link_ram.sv
rtl/core/linked_wait_queue_top.sv
tb/tb_linked_wait_queue_top.sv
